[rtl/ptsh_pkg.sv]
// Shared types and widths for the polynomial Taylor shift block.
// Used by ptsh_cell and polynomial_taylor_shift; depends on nothing else.
package ptsh_pkg;

   // Q16.16 word and the widths of the multiply-accumulate path.
   localparam int WORD_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * WORD_W;
   // Sum of a word and a rounded product (PROD_W - FRAC_W bits) plus one carry bit.
   localparam int SUM_W  = PROD_W - FRAC_W + 1;

   // Per-cycle commands sent from the sequencer to every cell.
   typedef struct packed {
      logic load;    // take the incoming coefficient and clear the overflow mark
      logic mul;     // multiply the upper neighbor's value by the shift point
      logic add;     // add the rounded product to the held value and saturate
      logic shift;   // take the upper neighbor's value (result drain)
   } ctl_type;

endpackage

[rtl/polynomial_taylor_shift.sv]
// Polynomial Taylor shift: rewrites f(x) in powers of (x - a), Q16.16, saturating.
// Load: one coefficient item per cycle; busy stays low until a last-marked item.
// After the last item is accepted the Horner passes run, then the results follow,
// one result per cycle; busy stays high through the passes and the drain.
// Results cannot be stalled. Reset (synchronous) empties the store, sets a = 0.
// Depends on ptsh_pkg and ptsh_cell.
module polynomial_taylor_shift
   import ptsh_pkg::*;
#(
   parameter int MAX_TERMS = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   // Coefficient input, command style.
   input  logic                     start,
   output logic                     busy,
   input  logic signed [WORD_W-1:0] req_coefficient,
   input  logic                     req_last_coefficient,
   // Shifted coefficients, one per strobe.
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_shifted_coefficient,
   output logic                     rsp_last_result,
   output logic                     rsp_overflow_seen,
   // Register port.
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [WORD_W-1:0]        pwdata,
   output logic [WORD_W-1:0]        prdata,
   output logic                     pready
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int IDX_W = $clog2(MAX_TERMS);
   localparam logic [2:0] ADDR_SHIFT_POINT = 3'd0;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CALC  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   // ------------------------------------------------------------------
   // Register port. The only register is the expansion point a.
   // ------------------------------------------------------------------
   logic signed [WORD_W-1:0] shift_point_ff;
   logic                     csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready & (paddr == ADDR_SHIFT_POINT);
   assign prdata    = (paddr == ADDR_SHIFT_POINT) ? shift_point_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_point_ff <= '0;
      end else if (csr_write) begin
         shift_point_ff <= pwdata;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer.
   // IDLE  : items are written into cell number count_ff (the store).
   // CALC  : the repeated Horner passes run as a wavefront down the chain.
   //         Each cell i updates its value as c[i] += a * c[i+1] once per
   //         pass, first a multiply, then a round/add/saturate.
   //         Pass j at cell i begins in wave step k = (n-2-i) + j, so the
   //         upper neighbor already holds its result of the same pass and the
   //         cell itself holds its result of the previous pass. Wave steps
   //         run from 0 to n-2; step_ff counts them and phase_ff picks the
   //         half of the step.
   // DRAIN : the chain shifts down one cell per cycle; cell 0 feeds the
   //         registered result ports, lowest degree first.
   // ------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic              phase_ff, phase_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic              accept;
   logic              has_room;
   logic [CNT_W-1:0]  count_loaded;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start & ~busy;
   // A full store drops the item, but its last mark still starts the shift.
   assign has_room     = (count_ff < CNT_W'(MAX_TERMS));
   assign count_loaded = count_ff + CNT_W'(has_room);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      left_in  = left_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = count_loaded;
               step_in  = '0;
               phase_in = 1'b0;
               left_in  = count_loaded;
               if (req_last_coefficient) begin
                  // A single term needs no passes.
                  state_in = (count_loaded == CNT_W'(1)) ? ST_DRAIN : ST_CALC;
               end
            end
         end
         ST_CALC: begin
            phase_in = ~phase_ff;
            if (phase_ff) begin
               if (step_ff == count_ff - CNT_W'(2)) begin
                  state_in = ST_DRAIN;
               end else begin
                  step_in = step_ff + CNT_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            left_in = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
               count_in = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         step_ff  <= '0;
         phase_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   // ------------------------------------------------------------------
   // The chain of cells. Cell i holds coefficient i; its upper neighbor is
   // cell i+1. The topmost cell sees zeros above it, which only matters
   // while draining, where those zeros never reach the output.
   // ------------------------------------------------------------------
   logic signed [WORD_W-1:0] cell_value [MAX_TERMS];
   logic                     cell_ovf   [MAX_TERMS];

   for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
      ctl_type                  ctl;
      logic signed [WORD_W-1:0] upper_value;
      logic                     upper_ovf;
      logic                     in_range;
      logic                     wave_here;

      if (i == MAX_TERMS - 1) begin : g_top
         assign upper_value = '0;
         assign upper_ovf   = 1'b0;
      end else begin : g_inner
         assign upper_value = cell_value[i+1];
         assign upper_ovf   = cell_ovf[i+1];
      end

      // Cell i takes part when i <= n-2, from wave step n-2-i onward.
      assign in_range  = ((CNT_W+1)'(i) + (CNT_W+1)'(2)) <= {1'b0, count_ff};
      assign wave_here = ((CNT_W+1)'(i) + {1'b0, step_ff} + (CNT_W+1)'(2))
                         >= {1'b0, count_ff};

      assign ctl.load  = accept & has_room & (count_ff[IDX_W-1:0] == IDX_W'(i));
      assign ctl.mul   = (state_ff == ST_CALC) & ~phase_ff & in_range & wave_here;
      assign ctl.add   = (state_ff == ST_CALC) &  phase_ff & in_range & wave_here;
      assign ctl.shift = (state_ff == ST_DRAIN);

      ptsh_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .shift_point (shift_point_ff),
         .load_value  (req_coefficient),
         .upper_value (upper_value),
         .upper_ovf   (upper_ovf),
         .value       (cell_value[i]),
         .ovf         (cell_ovf[i])
      );
   end

   // ------------------------------------------------------------------
   // Result register: one item per drain cycle, shown for exactly one cycle.
   // ------------------------------------------------------------------
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_value_ff;
   logic                     rsp_last_ff;
   logic                     rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DRAIN);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DRAIN) begin
         rsp_value_ff <= cell_value[0];
         rsp_last_ff  <= (left_ff == CNT_W'(1));
         rsp_ovf_ff   <= cell_ovf[0];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_shifted_coefficient = rsp_value_ff;
   assign rsp_last_result         = rsp_last_ff;
   assign rsp_overflow_seen       = rsp_ovf_ff;

endmodule

[rtl/ptsh_cell.sv]
// One cell of the Taylor shift chain: holds one coefficient and its overflow mark.
// Performs a two-stage saturating Q16.16 multiply-accumulate. Depends on ptsh_pkg.
module ptsh_cell
   import ptsh_pkg::*;
(
   input  logic                     clock,
   input  ctl_type                  ctl,
   input  logic signed [WORD_W-1:0] shift_point,
   input  logic signed [WORD_W-1:0] load_value,
   input  logic signed [WORD_W-1:0] upper_value,
   input  logic                     upper_ovf,
   output logic signed [WORD_W-1:0] value,
   output logic                     ovf
);

   logic signed [WORD_W-1:0] value_ff, value_in;
   logic                     ovf_ff, ovf_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     upper_ovf_ff;
   logic signed [SUM_W-1:0]  sum;
   logic                     sat;
   logic signed [WORD_W-1:0] clamped;

   assign prod_in = shift_point * upper_value;

   // Rounding by adding half an LSB then flooring equals flooring plus bit 15.
   always_comb begin
      sum = SUM_W'(value_ff) + SUM_W'($signed(prod_ff[PROD_W-1:FRAC_W]))
            + SUM_W'($unsigned(prod_ff[FRAC_W-1]));
      sat = (sum[SUM_W-1:WORD_W-1] != {(SUM_W-WORD_W+1){1'b0}}) &&
            (sum[SUM_W-1:WORD_W-1] != {(SUM_W-WORD_W+1){1'b1}});
      if (!sat) begin
         clamped = sum[WORD_W-1:0];
      end else if (sum[SUM_W-1]) begin
         clamped = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         clamped = {1'b0, {(WORD_W-1){1'b1}}};
      end
   end

   always_comb begin
      value_in = value_ff;
      ovf_in   = ovf_ff;
      priority if (ctl.load) begin
         value_in = load_value;
         ovf_in   = 1'b0;
      end else if (ctl.add) begin
         value_in = clamped;
         ovf_in   = ovf_ff | upper_ovf_ff | sat;
      end else if (ctl.shift) begin
         value_in = upper_value;
         ovf_in   = upper_ovf;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      ovf_ff   <= ovf_in;
      if (ctl.mul) begin
         prod_ff      <= prod_in;
         upper_ovf_ff <= upper_ovf;
      end
   end

   assign value = value_ff;
   assign ovf   = ovf_ff;

endmodule
